@@ src/grsd_pkg.sv @@
package grsd_pkg;

  localparam int FIR_TAPS    = 9;
  localparam int SMOOTH_LEN  = 5;
  localparam int SAMPLE_BITS = 16;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = $clog2(NUM_AXES);
  localparam int RATE_W     = 16;
  localparam int OUT_W      = 17;
  localparam int MOVE_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int WEIGHT_SCALE = 20;
  localparam int DIVISOR      = WEIGHT_SCALE * SMOOTH_LEN;
  localparam int PEAK         = (FIR_TAPS + 1) / 2;
  localparam int WEIGHT_SUM   = PEAK * (FIR_TAPS + 1 - PEAK);
  localparam int WT_W         = $clog2(PEAK + 1);
  localparam int FIR_W        = SAMPLE_BITS + $clog2(WEIGHT_SUM);
  localparam int SUM_W        = FIR_W + $clog2(SMOOTH_LEN);
  localparam int REM_W        = $clog2(DIVISOR);
  localparam int PROD_W       = SAMPLE_BITS + WT_W + 1;
  localparam int EXT_W        = (RATE_W > SAMPLE_BITS) ? RATE_W : SAMPLE_BITS;

  // Division by DIVISOR is a multiply by the rounded-up reciprocal, exact for
  // every dividend below 2**SUM_W.
  localparam int RECIP_SHIFT = SUM_W + REM_W;
  localparam int RECIP_W     = RECIP_SHIFT - REM_W + 1;
  localparam int QPROD_W     = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));
  localparam int DIV_STEPS   = 2;

  localparam int TAP_IDX_W = $clog2(FIR_TAPS);
  localparam int SM_IDX_W  = $clog2(SMOOTH_LEN);
  localparam int TAP_AW    = $clog2(NUM_AXES * FIR_TAPS);
  localparam int SM_AW     = $clog2(NUM_AXES * SMOOTH_LEN);

  localparam int CNT_MAX_A = (FIR_TAPS > SMOOTH_LEN) ? FIR_TAPS : SMOOTH_LEN;
  localparam int CNT_MAX   = (CNT_MAX_A > DIV_STEPS) ? CNT_MAX_A : DIV_STEPS;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);

  localparam int SMOOTH_MAX = 2 ** (OUT_W - 1) - 1;
  localparam int SMOOTH_MIN = -(2 ** (OUT_W - 1));

  localparam int DEAD_BAND_RESET = 164;

  localparam logic [CFG_IDX_W-1:0] CFG_REC_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_TAP,
    ST_SMOOTH,
    ST_DIV_SETUP,
    ST_DIVIDE,
    ST_DIV_DONE,
    ST_FINISH
  } grsd_state_t;

  // Triangular weight of tap i, counted back from the newest sample.
  function automatic logic [WT_W-1:0] tap_weight(input logic [TAP_IDX_W-1:0] i);
    int a;
    int b;
    begin
      a = int'(i) + 1;
      b = FIR_TAPS - int'(i);
      return (a < b) ? WT_W'(a) : WT_W'(b);
    end
  endfunction

  // The low SAMPLE_BITS bits of a rate field, as two's complement.
  function automatic logic signed [SAMPLE_BITS-1:0] sext_sample(input logic [RATE_W-1:0] v);
    logic [EXT_W-1:0] ext;
    begin
      ext = EXT_W'(v);
      return ext[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

@@ src/grsd_sample_if.sv @@
interface grsd_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [grsd_pkg::RATE_W-1:0] rate_x;
  logic signed [grsd_pkg::RATE_W-1:0] rate_y;
  logic signed [grsd_pkg::RATE_W-1:0] rate_z;
  logic                               set_baseline;
  logic                               clear_baseline;

  modport source (
    output valid, rate_x, rate_y, rate_z, set_baseline, clear_baseline,
    input  ready
  );
  modport sink (
    input  valid, rate_x, rate_y, rate_z, set_baseline, clear_baseline,
    output ready
  );
endinterface

@@ src/grsd_result_if.sv @@
interface grsd_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [grsd_pkg::OUT_W-1:0]  smooth_x;
  logic signed [grsd_pkg::OUT_W-1:0]  smooth_y;
  logic signed [grsd_pkg::OUT_W-1:0]  smooth_z;
  logic signed [grsd_pkg::MOVE_W-1:0] move_x;
  logic signed [grsd_pkg::MOVE_W-1:0] move_y;
  logic signed [grsd_pkg::MOVE_W-1:0] move_z;
  logic                               baseline_taken;

  modport source (
    output valid, smooth_x, smooth_y, smooth_z, move_x, move_y, move_z, baseline_taken,
    input  ready
  );
  modport sink (
    input  valid, smooth_x, smooth_y, smooth_z, move_x, move_y, move_z, baseline_taken,
    output ready
  );
endinterface

@@ src/grsd_cfg_if.sv @@
interface grsd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [grsd_pkg::CFG_IDX_W-1:0]      index;
  logic [grsd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/gyro_rate_smoothing_deadband.sv @@
// Three-axis gyro rate smoother. Each accepted sample is filtered per axis by
// a 9-tap triangular FIR (weights 1..5..1) followed by a 5-point moving
// average, and the smoothed value is floor(sum / 100), so the filter carries
// a DC gain of 1.25. In record mode a sample flagged set_baseline stores the
// three smoothed values as the baseline and reports zero moves; otherwise
// each move is the smoothed value minus the baseline, forced to zero when its
// magnitude is at or below dead_band. clear_baseline zeroes the baseline
// before the sample is handled. Filter history lives in two single-port-write
// RAMs that one shared multiply-accumulate walks, one entry per cycle, and the
// division by 100 is a multiply by a rounded-up reciprocal followed by a
// remainder check on the next cycle. A sample is accepted only in the idle
// state, so a new sample is taken only once the last one has been walked
// through both histories and divided for all three axes, and that serial
// walk sets most of the time that each sample takes.
// A finished result waits in an output register, so the next sample is taken
// while it is still pending. No clearing pass is needed after reset.
module gyro_rate_smoothing_deadband (
  input logic           clk,
  input logic           rst,
  grsd_sample_if.sink   sample,
  grsd_result_if.source result,
  grsd_cfg_if.sink      cfg
);
  import grsd_pkg::*;

  grsd_state_t state;
  grsd_state_t state_next;

  logic                        rec_enable;
  logic [CFG_DATA_W-1:0]       dead_band;

  logic [RATE_W-1:0]           rate_q [NUM_AXES];
  logic                        set_q;
  logic                        clr_q;

  logic [AXIS_W-1:0]           axis;
  logic [TAP_AW-1:0]           tap_base;
  logic [SM_AW-1:0]            sm_base;
  logic [TAP_IDX_W-1:0]        pos;
  logic [SM_IDX_W-1:0]         spos;
  logic [FIR_TAPS-1:0]         tap_valid;
  logic [SMOOTH_LEN-1:0]       sm_valid;
  logic [CNT_W-1:0]            cnt;

  logic signed [SUM_W-1:0]     acc;
  logic                        rd_pend;
  logic                        rd_ok;
  logic [WT_W-1:0]             rd_w;

  logic                        neg;
  logic [SUM_W-1:0]            mag;
  logic [SUM_W-1:0]            quo;
  logic [REM_W-1:0]            rem;

  logic signed [OUT_W-1:0]     smooth_q [NUM_AXES];
  logic signed [OUT_W-1:0]     baseline [NUM_AXES];

  // Memory ports.
  logic                        tap_we;
  logic [TAP_AW-1:0]           tap_waddr;
  logic [SAMPLE_BITS-1:0]      tap_wdata;
  logic [TAP_AW-1:0]           tap_raddr;
  logic [SAMPLE_BITS-1:0]      tap_rdata;
  logic                        sm_we;
  logic [SM_AW-1:0]            sm_waddr;
  logic [FIR_W-1:0]            sm_wdata;
  logic [SM_AW-1:0]            sm_raddr;
  logic [FIR_W-1:0]            sm_rdata;
  logic                        tap_re;
  logic                        sm_re;

  // Combinational helpers.
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic [TAP_IDX_W-1:0]        ti;
  logic [TAP_IDX_W:0]          tk_ext;
  logic [TAP_IDX_W-1:0]        tk;
  logic [SM_IDX_W-1:0]         si;
  logic [SM_IDX_W:0]           sk_ext;
  logic [SM_IDX_W-1:0]         sk;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SUM_W-1:0]     addend;
  logic [QPROD_W-1:0]          recip_prod;
  logic [SUM_W-1:0]            rem_diff;
  logic signed [SUM_W:0]       q_u;
  logic signed [SUM_W:0]       q_s;
  logic signed [OUT_W-1:0]     q_sat;
  logic                        capture;
  logic                        out_load;
  logic signed [MOVE_W-1:0]    move_v [NUM_AXES];

  grsd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NUM_AXES * FIR_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  grsd_ram #(.WIDTH(FIR_W), .DEPTH(NUM_AXES * SMOOTH_LEN)) u_sm_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_enable <= 1'b0;
      dead_band  <= CFG_DATA_W'(DEAD_BAND_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_REC_ENABLE: rec_enable <= cfg.data[0];
        CFG_DEAD_BAND:  dead_band  <= cfg.data;
        default: ;
      endcase
    end
  end

  // History addressing: tap i of the walk sits i slots behind the write slot.
  always_comb begin
    cur_sample = sext_sample(rate_q[axis]);
    ti = cnt[TAP_IDX_W-1:0];
    if ({1'b0, pos} >= {1'b0, ti}) begin
      tk_ext = {1'b0, pos} - {1'b0, ti};
    end else begin
      tk_ext = {1'b0, pos} + (TAP_IDX_W + 1)'(FIR_TAPS) - {1'b0, ti};
    end
    tk = tk_ext[TAP_IDX_W-1:0];
    si = cnt[SM_IDX_W-1:0];
    if ({1'b0, spos} >= {1'b0, si}) begin
      sk_ext = {1'b0, spos} - {1'b0, si};
    end else begin
      sk_ext = {1'b0, spos} + (SM_IDX_W + 1)'(SMOOTH_LEN) - {1'b0, si};
    end
    sk = sk_ext[SM_IDX_W-1:0];
  end

  // Multiply-accumulate operand; an entry never written since reset reads as zero.
  always_comb begin
    prod = PROD_W'($signed(tap_rdata)) * PROD_W'($signed({1'b0, rd_w}));
    if (!rd_ok) begin
      addend = '0;
    end else if (state == ST_TAP) begin
      addend = SUM_W'(prod);
    end else begin
      addend = SUM_W'($signed(sm_rdata));
    end
  end

  // Reciprocal quotient, the remainder it leaves, and the floor correction
  // for negative sums.
  always_comb begin
    recip_prod = QPROD_W'(mag) * QPROD_W'(RECIP);
    rem_diff   = mag - quo * SUM_W'(DIVISOR);
    q_u        = $signed({1'b0, quo});
    if (!neg) begin
      q_s = q_u;
    end else if (rem != '0) begin
      q_s = ~q_u;
    end else begin
      q_s = -q_u;
    end
    if (q_s > $signed((SUM_W + 1)'(SMOOTH_MAX))) begin
      q_sat = OUT_W'(SMOOTH_MAX);
    end else if (q_s < $signed((SUM_W + 1)'(SMOOTH_MIN))) begin
      q_sat = OUT_W'(SMOOTH_MIN);
    end else begin
      q_sat = q_s[OUT_W-1:0];
    end
  end

  always_comb begin
    logic signed [OUT_W-1:0]  base_eff;
    logic signed [MOVE_W-1:0] d;
    logic [MOVE_W-1:0]        dmag;
    capture = rec_enable && set_q;
    for (int a = 0; a < NUM_AXES; a++) begin
      base_eff = clr_q ? '0 : baseline[a];
      d        = MOVE_W'(smooth_q[a]) - MOVE_W'(base_eff);
      dmag     = d[MOVE_W-1] ? -d : d;
      if (!capture && (dmag > MOVE_W'(dead_band))) begin
        move_v[a] = d;
      end else begin
        move_v[a] = '0;
      end
    end
  end

  assign out_load = (state == ST_FINISH) && (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (sample.valid) state_next = ST_START;
      ST_START:     state_next = ST_TAP;
      ST_TAP:       if (cnt == CNT_W'(FIR_TAPS)) state_next = ST_SMOOTH;
      ST_SMOOTH:    if (cnt == CNT_W'(SMOOTH_LEN)) state_next = ST_DIV_SETUP;
      ST_DIV_SETUP: state_next = ST_DIVIDE;
      ST_DIVIDE:    if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_DIV_DONE;
      ST_DIV_DONE: begin
        if (axis == AXIS_W'(NUM_AXES - 1)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_START;
        end
      end
      ST_FINISH:    if (!result.valid || result.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = 1'b0;
    tap_we       = 1'b0;
    tap_waddr    = tap_base + TAP_AW'(pos);
    tap_wdata    = cur_sample;
    tap_re       = 1'b0;
    tap_raddr    = tap_base + TAP_AW'(tk);
    sm_we        = 1'b0;
    sm_waddr     = sm_base + SM_AW'(spos);
    sm_wdata     = acc[FIR_W-1:0];
    sm_re        = 1'b0;
    sm_raddr     = sm_base + SM_AW'(sk);
    case (state)
      ST_IDLE:   sample.ready = 1'b1;
      ST_START:  tap_we = 1'b1;
      ST_TAP:    tap_re = (cnt < CNT_W'(FIR_TAPS));
      ST_SMOOTH: begin
        sm_we = (cnt == CNT_W'(1));
        sm_re = (cnt < CNT_W'(SMOOTH_LEN));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
    end else begin
      state  <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      spos         <= '0;
      tap_valid    <= '0;
      sm_valid     <= '0;
      rd_pend      <= 1'b0;
      result.valid <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        baseline[a] <= '0;
      end
    end else begin
      rd_pend <= tap_re || sm_re;
      if (out_load) begin
        result.valid <= 1'b1;
        pos  <= (pos == TAP_IDX_W'(FIR_TAPS - 1)) ? '0 : pos + 1'b1;
        spos <= (spos == SM_IDX_W'(SMOOTH_LEN - 1)) ? '0 : spos + 1'b1;
        tap_valid[pos] <= 1'b1;
        sm_valid[spos] <= 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
          if (capture) begin
            baseline[a] <= smooth_q[a];
          end else if (clr_q) begin
            baseline[a] <= '0;
          end
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_ok <= (tap_re && tap_valid[tk]) || (sm_re && sm_valid[sk]);
    rd_w  <= tap_weight(ti);
    case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          rate_q[0] <= sample.rate_x;
          rate_q[1] <= sample.rate_y;
          rate_q[2] <= sample.rate_z;
          set_q     <= sample.set_baseline;
          clr_q     <= sample.clear_baseline;
          axis      <= '0;
          tap_base  <= '0;
          sm_base   <= '0;
        end
      end
      ST_START: begin
        // The newest tap has weight one.
        acc <= SUM_W'(cur_sample);
        cnt <= CNT_W'(1);
      end
      ST_TAP: begin
        if (rd_pend) begin
          acc <= acc + addend;
        end
        cnt <= (cnt == CNT_W'(FIR_TAPS)) ? CNT_W'(1) : cnt + 1'b1;
      end
      ST_SMOOTH: begin
        if (rd_pend) begin
          acc <= acc + addend;
        end
        cnt <= (cnt == CNT_W'(SMOOTH_LEN)) ? '0 : cnt + 1'b1;
      end
      ST_DIV_SETUP: begin
        neg <= acc[SUM_W-1];
        mag <= acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
        rem <= '0;
        cnt <= '0;
      end
      ST_DIVIDE: begin
        // Takes the quotient first, then the remainder it leaves.
        if (cnt == '0) begin
          quo <= SUM_W'(recip_prod[QPROD_W-1:RECIP_SHIFT]);
        end else begin
          rem <= rem_diff[REM_W-1:0];
        end
        cnt <= cnt + 1'b1;
      end
      ST_DIV_DONE: begin
        smooth_q[axis] <= q_sat;
        axis     <= axis + 1'b1;
        tap_base <= tap_base + TAP_AW'(FIR_TAPS);
        sm_base  <= sm_base + SM_AW'(SMOOTH_LEN);
      end
      ST_FINISH: begin
        if (out_load) begin
          result.smooth_x       <= smooth_q[0];
          result.smooth_y       <= smooth_q[1];
          result.smooth_z       <= smooth_q[2];
          result.move_x         <= move_v[0];
          result.move_y         <= move_v[1];
          result.move_z         <= move_v[2];
          result.baseline_taken <= capture;
        end
      end
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == ST_START)
    else $error("accepted sample did not start the first axis");

  a_tap_ports_apart: assert property (@(posedge clk) disable iff (rst)
    tap_we && tap_re |-> tap_waddr != tap_raddr)
    else $error("tap memory read and write hit the same entry");

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_DONE |-> int'(rem) < DIVISOR)
    else $error("divider remainder out of range");

  a_slots_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(pos) < FIR_TAPS && int'(spos) < SMOOTH_LEN)
    else $error("history write slot out of range");

  a_capture_quiet: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.baseline_taken |->
      result.move_x == '0 && result.move_y == '0 && result.move_z == '0)
    else $error("baseline capture beat carries a nonzero move");

endmodule

@@ src/grsd_ram.sv @@
module grsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
